// ----- sv/first_fit_segment_allocator_core_defines.svh -----
// Assertion macros used by the allocator core module.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_CORE_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define FFSA_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define FFSA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/ffsa_pkg.sv -----
`default_nettype none

package ffsa_pkg;

  // Command codes.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_LOADED    = 2'd3;

  // Input request.
  typedef struct packed {
    logic        cmd;
    logic [15:0] size_kb;
  } req_t;

  // Result.
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [15:0] request_number;
    logic [15:0] remainder_kb;
  } rsp_t;

  // One entry of the segment table.
  typedef struct packed {
    logic [15:0] size_kb;
    logic        free;
  } seg_t;

endpackage

`default_nettype wire

// ----- sv/ffsa_ram.sv -----
`default_nettype none

module ffsa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/first_fit_segment_allocator_core.sv -----
// First-fit segment allocator.
// Input channel in_valid_i/in_ready_o carries a request: cmd 0 appends a free
// segment of size_kb to the table, cmd 1 asks for size_kb from the first free
// segment large enough. Every request gives exactly one result on the output
// channel out_valid_o/out_ready_i, in request order.
// The segment table lives in a single-port-write, registered-read memory of
// MAX_SEGMENTS entries. A load writes the table on acceptance and hands its
// result through S_RESP to the output register. An allocation scans the table
// one entry per cycle through the memory read port: an exact fit marks the
// entry allocated, and a search with no fit ends once every entry is checked.
// A split moves each later entry up by one at one entry per cycle, then writes
// the free remainder and the allocated part. One request is worked on at a
// time; the next is accepted the cycle after a result has moved into the
// output register.
// The result sits in an output register: a stalled receiver does not stop the
// next request from being accepted and processed; only the hand-over of that
// next result waits for the register to be emptied.
// Reset empties the table (count zero) and clears the request counter; table
// memory contents are not cleared, since only entries below the count are read.
`default_nettype none
`include "first_fit_segment_allocator_core_defines.svh"

module first_fit_segment_allocator_core #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ffsa_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ffsa_pkg::rsp_t      out_rsp_o
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WR_REM,
    S_WR_ALLOC,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [15:0]        reqno_q, reqno_d;
  logic [15:0]        size_q, size_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [15:0]        hit_size_q, hit_size_d;
  logic [15:0]        rem_q, rem_d;
  logic [CNT_W-1:0]   shf_q, shf_d;
  logic               shv_q, shv_d;
  logic [IDX_W-1:0]   shsrc_q, shsrc_d;
  ffsa_pkg::rsp_t     res_q, res_d;
  ffsa_pkg::rsp_t     out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  ffsa_pkg::seg_t     ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [$bits(ffsa_pkg::seg_t)-1:0] ram_rdata;
  ffsa_pkg::seg_t     rd_seg;
  logic               issue;
  logic               more;
  logic               hit_fit;

  // Segment table memory.
  ffsa_ram #(
    .WIDTH ($bits(ffsa_pkg::seg_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_seg      = ffsa_pkg::seg_t'(ram_rdata);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The entry returned by the memory this cycle is free and large enough.
  assign hit_fit = chk_vld_q && rd_seg.free && (rd_seg.size_kb >= size_q);

  // Sequencer: scan, shift, write back, hand over result.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    reqno_d     = reqno_q;
    size_d      = size_q;
    iss_d       = iss_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    hit_idx_d   = hit_idx_q;
    hit_size_d  = hit_size_q;
    rem_d       = rem_q;
    shf_d       = shf_q;
    shv_d       = shv_q;
    shsrc_d     = shsrc_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = iss_q[IDX_W-1:0];
    issue       = 1'b0;
    more        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.cmd == ffsa_pkg::CMD_LOAD) begin
            if (count_q == CNT_MAX) begin
              res_d = '{ffsa_pkg::ST_FULL, 6'd0, 16'd0, 16'd0};
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IDX_W-1:0];
              ram_wdata = '{in_req_i.size_kb, 1'b1};
              res_d     = '{ffsa_pkg::ST_LOADED, 6'(count_q), 16'd0, 16'd0};
              count_d   = count_q + CNT_W'(1);
            end
            state_d = S_RESP;
          end else begin
            reqno_d = reqno_q + 16'd1;
            size_d  = in_req_i.size_kb;
            if (count_q == '0) begin
              res_d   = '{ffsa_pkg::ST_NO_FIT, 6'd0, reqno_q + 16'd1, 16'd0};
              state_d = S_RESP;
            end else begin
              iss_d     = '0;
              chk_vld_d = 1'b0;
              state_d   = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; the data is checked in the next cycle.
        issue     = (iss_q < count_q);
        ram_raddr = iss_q[IDX_W-1:0];
        iss_d     = issue ? iss_q + CNT_W'(1) : iss_q;
        chk_vld_d = issue;
        chk_idx_d = iss_q[IDX_W-1:0];
        if (hit_fit) begin
          hit_idx_d  = chk_idx_q;
          hit_size_d = rd_seg.size_kb;
          chk_vld_d  = 1'b0;
          if (rd_seg.size_kb == size_q) begin
            rem_d   = 16'd0;
            state_d = S_WR_ALLOC;
          end else if (count_q == CNT_MAX) begin
            res_d   = '{ffsa_pkg::ST_FULL, 6'd0, reqno_q, 16'd0};
            state_d = S_RESP;
          end else begin
            shf_d   = count_q - CNT_W'(1);
            shv_d   = 1'b0;
            state_d = S_SHIFT;
          end
        end else if (!chk_vld_q && !issue) begin
          res_d   = '{ffsa_pkg::ST_NO_FIT, 6'd0, reqno_q, 16'd0};
          state_d = S_RESP;
        end
      end

      S_SHIFT: begin
        // Read entry k-1 and write it to k on the next cycle, top down.
        more      = (shf_q > CNT_W'(hit_idx_q));
        ram_raddr = shf_q[IDX_W-1:0];
        if (shv_q) begin
          ram_we    = 1'b1;
          ram_waddr = shsrc_q + IDX_W'(1);
          ram_wdata = rd_seg;
        end
        shv_d   = more;
        shsrc_d = shf_q[IDX_W-1:0];
        if (more) begin
          shf_d = shf_q - CNT_W'(1);
        end
        if (!more && !shv_q) begin
          state_d = S_WR_REM;
        end
      end

      S_WR_REM: begin
        // The free remainder goes just above the allocated part.
        ram_we    = 1'b1;
        ram_waddr = hit_idx_q + IDX_W'(1);
        ram_wdata = '{hit_size_q - size_q, 1'b1};
        rem_d     = hit_size_q - size_q;
        count_d   = count_q + CNT_W'(1);
        state_d   = S_WR_ALLOC;
      end

      S_WR_ALLOC: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx_q;
        ram_wdata = '{size_q, 1'b0};
        res_d     = '{ffsa_pkg::ST_ALLOCATED, 6'(hit_idx_q), reqno_q, rem_q};
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      reqno_q     <= '0;
      size_q      <= '0;
      iss_q       <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      hit_idx_q   <= '0;
      hit_size_q  <= '0;
      rem_q       <= '0;
      shf_q       <= '0;
      shv_q       <= 1'b0;
      shsrc_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      reqno_q     <= reqno_d;
      size_q      <= size_d;
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      hit_idx_q   <= hit_idx_d;
      hit_size_q  <= hit_size_d;
      rem_q       <= rem_d;
      shf_q       <= shf_d;
      shv_q       <= shv_d;
      shsrc_q     <= shsrc_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The segment count never passes the table depth.
  `FFSA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_MAX, "segment count above depth")
  // In idle the table is written only by an accepted load.
  `FFSA_ASSERT_NOW(a_idle_write, ram_we && (state_q == S_IDLE),
                   in_valid_i && (in_req_i.cmd == ffsa_pkg::CMD_LOAD), "stray table write")
  // A load into a table with room grows the count by one.
  `FFSA_ASSERT_NEXT(a_load_count, in_valid_i && in_ready_o &&
                    (in_req_i.cmd == ffsa_pkg::CMD_LOAD) && (count_q != CNT_MAX),
                    count_q == $past(count_q) + CNT_W'(1), "load did not grow table")
  // A shift write never goes beyond the current end of the table.
  `FFSA_ASSERT_NOW(a_shift_range, ram_we && (state_q == S_SHIFT),
                   CNT_W'(ram_waddr) <= count_q, "shift write past table end")
  // Each accepted allocation request takes exactly one request number.
  `FFSA_ASSERT_NEXT(a_reqno_step, in_valid_i && in_ready_o &&
                    (in_req_i.cmd == ffsa_pkg::CMD_REQUEST),
                    reqno_q == $past(reqno_q) + 16'd1, "request number not advanced")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;

  localparam int SEGS = 64;
  localparam int RANDOM_ITEMS = 1200;
  // Back-to-back requests on the empty table before the directed part.
  localparam int EMPTY_ITEMS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  // Two copies of the allocator state: one follows accepted requests for checking,
  // the other follows queued requests so that stimulus can aim at free segments.
  localparam int TRACK_ACCEPTED = 0;
  localparam int TRACK_QUEUED = 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  ffsa_pkg::req_t in_req_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  ffsa_pkg::rsp_t out_rsp_o;

  // Segment table copies, indexed by the tracking view.
  bit [15:0] tab_size [2][SEGS];
  bit tab_free [2][SEGS];
  int unsigned tab_count [2];
  bit [15:0] tab_reqno [2];

  ffsa_pkg::req_t alloc_reqs_pending [$];
  ffsa_pkg::rsp_t alloc_results_due [$];

  bit idle_on = 1'b0;
  int unsigned hold_after = 0;
  int unsigned items_queued = 0;
  int unsigned rsp_seen = 0;
  int unsigned err_count = 0;

  first_fit_segment_allocator_core #(
    .MAX_SEGMENTS(SEGS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one request to a view of the table and return the result it must give.
  function automatic ffsa_pkg::rsp_t first_fit_outcome(input int view,
                                                       input ffsa_pkg::req_t r);
    ffsa_pkg::rsp_t res;
    int unsigned j;
    int unsigned k;
    res = '0;
    if (r.cmd == ffsa_pkg::CMD_LOAD) begin
      if (tab_count[view] >= SEGS) begin
        res.status = ffsa_pkg::ST_FULL;
      end else begin
        j = tab_count[view];
        tab_size[view][j] = r.size_kb;
        tab_free[view][j] = 1'b1;
        tab_count[view] = j + 1;
        res.status = ffsa_pkg::ST_LOADED;
        res.position = 6'(j);
      end
      return res;
    end
    tab_reqno[view] = tab_reqno[view] + 16'd1;
    res.request_number = tab_reqno[view];
    j = 0;
    while (j < tab_count[view] && !(tab_free[view][j] && tab_size[view][j] >= r.size_kb))
      j++;
    if (j >= tab_count[view]) begin
      res.status = ffsa_pkg::ST_NO_FIT;
    end else if (tab_size[view][j] == r.size_kb) begin
      tab_free[view][j] = 1'b0;
      res.status = ffsa_pkg::ST_ALLOCATED;
      res.position = 6'(j);
    end else if (tab_count[view] >= SEGS) begin
      res.status = ffsa_pkg::ST_FULL;
    end else begin
      // Split: later entries move up and the free remainder follows the new block.
      for (k = tab_count[view]; k > j + 1; k--) begin
        tab_size[view][k] = tab_size[view][k - 1];
        tab_free[view][k] = tab_free[view][k - 1];
      end
      tab_size[view][j + 1] = tab_size[view][j] - r.size_kb;
      tab_free[view][j + 1] = 1'b1;
      tab_size[view][j] = r.size_kb;
      tab_free[view][j] = 1'b0;
      tab_count[view] = tab_count[view] + 1;
      res.status = ffsa_pkg::ST_ALLOCATED;
      res.position = 6'(j);
      res.remainder_kb = tab_size[view][j + 1];
    end
    return res;
  endfunction

  // Index of a randomly chosen free segment in the queued view, or -1 if none.
  function automatic int free_segment_pick();
    int nfree;
    int k;
    int pick;
    nfree = 0;
    for (k = 0; k < int'(tab_count[TRACK_QUEUED]); k++)
      if (tab_free[TRACK_QUEUED][k]) nfree++;
    if (nfree == 0) return -1;
    pick = int'($urandom_range(nfree - 1, 0));
    for (k = 0; k < int'(tab_count[TRACK_QUEUED]); k++) begin
      if (tab_free[TRACK_QUEUED][k]) begin
        if (pick == 0) return k;
        pick--;
      end
    end
    return -1;
  endfunction

  function automatic void queue_request(input logic cmd, input logic [15:0] size);
    ffsa_pkg::req_t r;
    r.cmd = cmd;
    r.size_kb = size;
    alloc_reqs_pending.insert(alloc_reqs_pending.size(), r);
    void'(first_fit_outcome(TRACK_QUEUED, r));
    items_queued++;
  endfunction

  // Wait until every queued request has been taken and answered.
  task automatic settle();
    while (alloc_reqs_pending.size() != 0 || in_valid_i || alloc_results_due.size() != 0)
      @(negedge clk_i);
  endtask

  // Request driver: once idle_on is set, a random gap is drawn after each accepted request.
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    int unsigned send_gap;
    logic nxt_valid;
    ffsa_pkg::req_t nxt_req;
    if (!rst_ni) begin
      send_gap = 0;
      in_valid_i <= 1'b0;
      in_req_i <= '0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_req = in_req_i;
      if (in_valid_i && in_ready_o) begin
        alloc_results_due.insert(alloc_results_due.size(),
                                 first_fit_outcome(TRACK_ACCEPTED, in_req_i));
        nxt_valid = 1'b0;
        send_gap = idle_on ? $urandom_range(15, 0) : 0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (alloc_reqs_pending.size() != 0) begin
          nxt_req = alloc_reqs_pending.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
      in_req_i <= nxt_req;
    end
  end

  // Result monitor: checks each result against the oldest one due, then stalls a while.
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    int unsigned ack_wait;
    int unsigned w;
    ffsa_pkg::rsp_t want;
    if (!rst_ni) begin
      ack_wait = 0;
      out_ready_i <= 1'b0;
    end else if (out_ready_i && out_valid_o) begin
      rsp_seen++;
      if (alloc_results_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result %0d: status %0d position %0d number %0d remainder %0d",
                   rsp_seen, out_rsp_o.status, out_rsp_o.position,
                   out_rsp_o.request_number, out_rsp_o.remainder_kb);
      end else begin
        want = alloc_results_due.pop_front();
        if (out_rsp_o.status !== want.status || out_rsp_o.position !== want.position ||
            out_rsp_o.request_number !== want.request_number ||
            out_rsp_o.remainder_kb !== want.remainder_kb) begin
          err_count++;
          if (err_count <= 10)
            $display("result %0d differs: status %0d/%0d position %0d/%0d number %0d/%0d %s%0d/%0d",
                     rsp_seen, want.status, out_rsp_o.status, want.position,
                     out_rsp_o.position, want.request_number, out_rsp_o.request_number,
                     "remainder ", want.remainder_kb, out_rsp_o.remainder_kb);
        end
      end
      w = idle_on ? $urandom_range(15, 0) : 0;
      // One long hold-off so that the block backs up and stops taking requests.
      if (rsp_seen == hold_after) w = HOLD_CYCLES;
      ack_wait = w;
      out_ready_i <= (w == 0);
    end else if (!out_ready_i) begin
      if (ack_wait > 0) ack_wait--;
      if (ack_wait == 0) out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither channel moves a request or a result.
  always @(posedge clk_i) begin : quiet_watch
    int unsigned quiet_cycles;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Stimulus.
  initial begin : stimulus
    int n;
    int idx;
    int unsigned roll;
    int unsigned pick;
    logic [15:0] size;
    tab_count[TRACK_ACCEPTED] = 0;
    tab_count[TRACK_QUEUED] = 0;
    tab_reqno[TRACK_ACCEPTED] = '0;
    tab_reqno[TRACK_QUEUED] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Back-to-back requests on the empty table.
    for (n = 0; n < EMPTY_ITEMS; n++) queue_request(ffsa_pkg::CMD_REQUEST, 16'($urandom));
    settle();
    idle_on = 1'b1;

    // Directed: size extremes, exact fits, splits, zero-size requests, no fit,
    // and a load after requests.
    queue_request(ffsa_pkg::CMD_REQUEST, 16'd0);
    queue_request(ffsa_pkg::CMD_LOAD, 16'd0);
    queue_request(ffsa_pkg::CMD_LOAD, 16'd100);
    queue_request(ffsa_pkg::CMD_LOAD, 16'hFFFF);
    queue_request(ffsa_pkg::CMD_LOAD, 16'd1);
    queue_request(ffsa_pkg::CMD_LOAD, 16'd100);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'd0);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'd100);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'hFFFF);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'd0);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'd101);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'd1);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'd60);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'hFFFF);
    queue_request(ffsa_pkg::CMD_LOAD, 16'hFFFF);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'd40);
    queue_request(ffsa_pkg::CMD_REQUEST, 16'hFFFE);
    settle();

    // Random part: mostly requests aimed at free segments, so the table fills up,
    // with loads of mixed sizes and unaimed requests as noise.
    hold_after = items_queued + 150;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) settle();
      roll = $urandom_range(99, 0);
      pick = $urandom_range(99, 0);
      if (roll < 25) begin
        if (pick < 10) size = 16'd0;
        else if (pick < 20) size = 16'hFFFF;
        else if (pick < 50) size = 16'($urandom_range(255, 0));
        else size = 16'($urandom);
        queue_request(ffsa_pkg::CMD_LOAD, size);
      end else begin
        idx = free_segment_pick();
        if (idx >= 0 && pick < 40)
          size = tab_size[TRACK_QUEUED][idx];
        else if (idx >= 0 && pick < 65 && tab_size[TRACK_QUEUED][idx] != 0)
          size = 16'($urandom_range(tab_size[TRACK_QUEUED][idx] - 1, 0));
        else if (pick < 70)
          size = 16'd0;
        else if (pick < 75)
          size = 16'hFFFF;
        else
          size = 16'($urandom);
        queue_request(ffsa_pkg::CMD_REQUEST, size);
      end
    end
    settle();
    repeat (2 * SEGS + 20) @(negedge clk_i);

    if (err_count == 0 && alloc_results_due.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
